// ===== rtl/max_forward_weight_order_dp_assert.svh =====
// Assertion macros used by the checker file
`ifndef MAX_FORWARD_WEIGHT_ORDER_DP_ASSERT_SVH
`define MAX_FORWARD_WEIGHT_ORDER_DP_ASSERT_SVH

// implication checked every cycle outside reset
`define MFW_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed in %m");

// next-cycle implication checked outside reset
`define MFW_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed in %m");

`endif

// ===== rtl/mfw_pkg.sv =====
`default_nettype none
package mfw_pkg;
   localparam int MaxNodes   = 16;
   localparam int WeightBits = 16;
   localparam int NodeBits   = 4;
   localparam int CountBits  = 5;
   localparam int BestBits   = 23;
   localparam int SetBits    = 16;
   localparam int PackBits   = 64;
   localparam int WAddrBits  = 8;
endpackage
`default_nettype wire

// ===== rtl/max_forward_weight_order_dp.sv =====
// A non-last arc is written to the weight store when accepted. A last arc is
//   also stored, then starts the subset sweep (one weight-matrix read per
//   cycle through a single accumulator), then traceback, and a clear of all
//   256 weight-store entries once the item leaves.
// Throughput: one item at a time; input stalls from last arc until clear ends.
// Reset: synchronous active high; node_count to 11, then the store clear.
`default_nettype none
module max_forward_weight_order_dp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [4:0]  csr_node_count,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_tail_node,
   input  wire logic [3:0]  req_head_node,
   input  wire logic [15:0] req_weight,
   input  wire logic        req_last_arc,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [22:0]      rsp_best_weight,
   output logic [63:0]      rsp_order_packed
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SET, ST_VSEL, ST_SUM, ST_PREAD, ST_CMP, ST_STORE,
      ST_TRACE, ST_TWAIT, ST_OUT
   } state_type;

   state_type state_ff;
   logic [mfw_pkg::CountBits-1:0] ncfg_ff;
   logic [mfw_pkg::CountBits-1:0] n_ff;
   logic [mfw_pkg::WAddrBits-1:0] clr_ff;
   logic [mfw_pkg::SetBits:0]     set_ff;     // wide enough to pass full
   logic [mfw_pkg::NodeBits:0]    v_ff;       // candidate vertex, counts down
   logic [mfw_pkg::NodeBits:0]    u_ff;       // summing vertex
   logic [mfw_pkg::BestBits-1:0]  acc_ff;
   logic [mfw_pkg::BestBits-1:0]  cur_ff;
   logic [mfw_pkg::NodeBits-1:0]  par_ff;
   logic                          have_ff;
   logic [mfw_pkg::SetBits-1:0]   tset_ff;
   logic [mfw_pkg::NodeBits:0]    k_ff;
   logic [mfw_pkg::PackBits-1:0]  pack_ff;
   logic [mfw_pkg::BestBits-1:0]  bestw_ff;

   // memories
   logic [mfw_pkg::WeightBits-1:0] wmem [0:(1<<mfw_pkg::WAddrBits)-1];
   logic [mfw_pkg::BestBits-1:0]   bmem [0:(1<<mfw_pkg::SetBits)-1];
   logic [mfw_pkg::NodeBits-1:0]   pmem [0:(1<<mfw_pkg::SetBits)-1];
   logic [mfw_pkg::WeightBits-1:0] wrd_ff;
   logic [mfw_pkg::BestBits-1:0]   brd_ff;
   logic [mfw_pkg::NodeBits-1:0]   prd_ff;

   logic [mfw_pkg::SetBits-1:0] full;
   logic [mfw_pkg::SetBits-1:0] cur_set;
   logic [mfw_pkg::SetBits-1:0] vbit;
   logic [mfw_pkg::SetBits-1:0] pred;
   logic accept;
   logic [mfw_pkg::BestBits-1:0] cand;

   assign full    = mfw_pkg::SetBits'((17'(1) << n_ff) - 17'(1));
   assign cur_set = set_ff[mfw_pkg::SetBits-1:0];
   assign vbit    = mfw_pkg::SetBits'(1) << v_ff[mfw_pkg::NodeBits-1:0];
   assign pred    = cur_set ^ vbit;
   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_best_weight  = bestw_ff;
   assign rsp_order_packed = pack_ff;
   // the empty set scores zero and is never stored
   assign cand = ((pred == '0) ? '0 : brd_ff) + acc_ff;

   // weight store: write on arc or clear, read one column entry per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         wmem[clr_ff] <= '0;
      end else if (accept) begin
         wmem[{req_tail_node, req_head_node}] <= req_weight;
      end
      wrd_ff <= wmem[{u_ff[mfw_pkg::NodeBits-1:0], v_ff[mfw_pkg::NodeBits-1:0]}];
   end

   // DP tables
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         bmem[cur_set] <= cur_ff;
         pmem[cur_set] <= par_ff;
      end
      brd_ff <= bmem[(state_ff == ST_TRACE || state_ff == ST_TWAIT) ? tset_ff : pred];
      prd_ff <= pmem[tset_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ncfg_ff  <= 5'd11;
      end else begin
         if (csr_write) ncfg_ff <= csr_node_count;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept && req_last_arc) begin
                  n_ff   <= (ncfg_ff > 5'd16) ? 5'd16 : ncfg_ff;
                  set_ff <= 17'd1;
                  state_ff <= ST_SET;
               end
            end
            ST_SET: begin
               // start a subset, or once all subsets are done trace back (output directly if n is zero)
               if (set_ff > {1'b0, full}) begin
                  tset_ff  <= full;
                  k_ff     <= n_ff;
                  pack_ff  <= '0;
                  bestw_ff <= (n_ff == 0) ? '0 : cur_ff;
                  state_ff <= (n_ff == 0) ? ST_OUT : ST_TRACE;
               end else begin
                  v_ff    <= n_ff - 1'b1;
                  have_ff <= 1'b0;
                  cur_ff  <= '0;
                  par_ff  <= '0;
                  state_ff <= ST_VSEL;
               end
            end
            ST_VSEL: begin
               if (!cur_set[v_ff[mfw_pkg::NodeBits-1:0]]) begin
                  if (v_ff == 0) state_ff <= ST_STORE;
                  else v_ff <= v_ff - 1'b1;
               end else begin
                  u_ff   <= '0;
                  acc_ff <= '0;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               // wrd_ff is registered from u_ff, so it holds the previous vertex; the pass at u_ff == n_ff flushes it
               if (u_ff != 0 && pred[u_ff[mfw_pkg::NodeBits-1:0] - 1'b1])
                  acc_ff <= acc_ff + mfw_pkg::BestBits'(wrd_ff);
               if (u_ff == n_ff) state_ff <= ST_PREAD;
               else u_ff <= u_ff + 1'b1;
            end
            ST_PREAD: state_ff <= ST_CMP;
            ST_CMP: begin
               if (!have_ff || cand > cur_ff) begin
                  have_ff <= 1'b1;
                  cur_ff  <= cand;
                  par_ff  <= v_ff[mfw_pkg::NodeBits-1:0];
               end
               if (v_ff == 0) state_ff <= ST_STORE;
               else begin
                  v_ff <= v_ff - 1'b1;
                  state_ff <= ST_VSEL;
               end
            end
            ST_STORE: begin
               set_ff <= set_ff + 1'b1;
               state_ff <= ST_SET;
            end
            ST_TRACE: state_ff <= ST_TWAIT;
            ST_TWAIT: begin
               pack_ff <= pack_ff | (mfw_pkg::PackBits'(prd_ff) << (6'(k_ff - 1'b1) << 2));
               tset_ff <= tset_ff ^ (mfw_pkg::SetBits'(1) << prd_ff);
               k_ff    <= k_ff - 1'b1;
               if (k_ff == 1) begin
                  clr_ff   <= '0;
                  state_ff <= ST_OUT;
               end else state_ff <= ST_TRACE;
            end
            ST_OUT: begin
               if (!rsp_stall) state_ff <= ST_CLEAR;
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/mfw_checker.sv =====
`default_nettype none
`include "max_forward_weight_order_dp_assert.svh"
module mfw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [22:0] rsp_best_weight,
   input wire logic [63:0] rsp_order_packed
);
   `MFW_ASSERT_IMP(no_accept_while_rsp, clock, reset, rsp_valid, req_stall)
   `MFW_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_best_weight) && $stable(rsp_order_packed))
   `MFW_ASSERT_NEXT(busy_after_rsp, clock, reset, rsp_valid && !rsp_stall,
      !rsp_valid && req_stall)
endmodule
bind max_forward_weight_order_dp mfw_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_best_weight(rsp_best_weight), .rsp_order_packed(rsp_order_packed));
`default_nettype wire
